/* hdl/utf8d_pkg.sv */
package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 31;
  localparam int unsigned RemW  = 3;
  localparam int unsigned StW   = 2;

  typedef enum logic [StW-1:0] {
    StOk      = 2'd0,
    StBadLead = 2'd1,
    StBadCont = 2'd2,
    StTrunc   = 2'd3
  } status_e;

  typedef struct packed {
    logic               emit;
    logic [CpW-1:0]     code_point;
    status_e            status;
    logic               eos;
  } result_t;

endpackage

/* hdl/utf8d_if.sv */
interface utf8d_in_if;
  logic                          valid;
  logic                          ready;
  logic [utf8d_pkg::ByteW-1:0]   in_byte;
  logic                          last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface utf8d_out_if;
  logic                          valid;
  logic                          ready;
  logic [utf8d_pkg::CpW-1:0]     code_point;
  logic [utf8d_pkg::StW-1:0]     status;
  logic                          end_of_string;

  modport source (output valid, output code_point, output status, output end_of_string,
                  input ready);
  modport sink   (input valid, input code_point, input status, input end_of_string,
                  output ready);
endinterface

/* hdl/utf8_stream_decoder.sv */
// UTF-8 stream decoder, extended lead bytes of 1 to 6 bytes, code points up to 31 bits.
// Input channel in_i: one byte per word (in_byte) and last_byte marking the final byte
// of a string. Output channel out_o: code_point, status (ok, bad lead, bad continuation,
// truncated sequence) and end_of_string; code_point is zero on any error status.
// A word goes out when a sequence completes or an error is found; other bytes give none.
// After an error, bytes up to and including the next last_byte are dropped.
// Path: a result is valid on out_o once its byte, held in the input register, advances and
// one decode step fills the output register; a stall on out_o can hold the byte in between.
// Throughput: one byte per clock while out_o is free or the byte produces no word; the
// decode step updates the sequence state each time a byte leaves the input register.
// Stall: when out_o is not ready the result holds in the output register; bytes that
// produce no word keep flowing through the input register, and in_i.ready drops once the
// byte in the input register would also produce a result.
// Reset: rst_ni clears both registers' valid flags and the sequence state, so decoding
// starts at a lead byte with nothing pending.
module utf8_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  utf8d_in_if.sink    in_i,
  utf8d_out_if.source out_o
);

  logic                        s1_valid_q;
  logic [utf8d_pkg::ByteW-1:0] s1_byte_q;
  logic                        s1_last_q;
  logic                        out_valid_q;
  logic [utf8d_pkg::CpW-1:0]   out_cp_q;
  logic [utf8d_pkg::StW-1:0]   out_st_q;
  logic                        out_eos_q;
  logic                        out_free;
  logic                        s1_adv;
  logic                        in_acc;
  utf8d_pkg::result_t          res;

  utf8d_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s1_adv),
    .byte_i    (s1_byte_q),
    .last_i    (s1_last_q),
    .res_o     (res)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && (!res.emit || out_free);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= in_i.in_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res.emit) begin
      out_cp_q  <= res.code_point;
      out_st_q  <= res.status;
      out_eos_q <= res.eos;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.code_point    = out_cp_q;
  assign out_o.status        = out_st_q;
  assign out_o.end_of_string = out_eos_q;

  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && res.emit |=> out_valid_q)
    else $error("result lost on its way to the output register");

  a_err_zero_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_st_q != utf8d_pkg::StOk |-> out_cp_q == '0)
    else $error("nonzero code point with error status");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_byte_q) && $stable(s1_last_q))
    else $error("stalled input byte lost");

endmodule

/* hdl/utf8d_core.sv */
module utf8d_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         advance_i,
  input  logic [utf8d_pkg::ByteW-1:0]  byte_i,
  input  logic                         last_i,
  output utf8d_pkg::result_t           res_o
);

  logic [utf8d_pkg::RemW-1:0] rem_q, rem_d, rem_dec;
  logic [utf8d_pkg::CpW-1:0]  part_q, part_d, part_new, lead_bits, cont_bits;
  logic                       disc_q, disc_d;
  logic [utf8d_pkg::RemW-1:0] need;
  logic                       lead_bad;

  always_comb begin
    need      = '0;
    lead_bits = '0;
    lead_bad  = 1'b0;
    case (byte_i) inside
      8'b0???????: need = '0;
      8'b110?????: begin
        need      = 3'd1;
        lead_bits = {20'b0, byte_i[4:0], 6'b0};
      end
      8'b1110????: begin
        need      = 3'd2;
        lead_bits = {15'b0, byte_i[3:0], 12'b0};
      end
      8'b11110???: begin
        need      = 3'd3;
        lead_bits = {10'b0, byte_i[2:0], 18'b0};
      end
      8'b111110??: begin
        need      = 3'd4;
        lead_bits = {5'b0, byte_i[1:0], 24'b0};
      end
      8'b1111110?: begin
        need      = 3'd5;
        lead_bits = {byte_i[0], 30'b0};
      end
      default: lead_bad = 1'b1;
    endcase
  end

  assign rem_dec = rem_q - 3'd1;

  always_comb begin
    case (rem_dec)
      3'd0:    cont_bits = {25'b0, byte_i[5:0]};
      3'd1:    cont_bits = {19'b0, byte_i[5:0], 6'b0};
      3'd2:    cont_bits = {13'b0, byte_i[5:0], 12'b0};
      3'd3:    cont_bits = {7'b0, byte_i[5:0], 18'b0};
      3'd4:    cont_bits = {1'b0, byte_i[5:0], 24'b0};
      default: cont_bits = '0;
    endcase
  end

  assign part_new = part_q | cont_bits;

  always_comb begin
    rem_d              = rem_q;
    part_d             = part_q;
    disc_d             = disc_q;
    res_o.emit         = 1'b0;
    res_o.code_point   = '0;
    res_o.status       = utf8d_pkg::StOk;
    res_o.eos          = last_i;
    if (disc_q) begin
      if (last_i) begin
        disc_d = 1'b0;
      end
    end else if (rem_q == '0) begin
      if (lead_bad) begin
        res_o.emit   = 1'b1;
        res_o.status = utf8d_pkg::StBadLead;
        disc_d       = !last_i;
      end else if (need == '0) begin
        res_o.emit       = 1'b1;
        res_o.code_point = {23'b0, byte_i};
      end else if (last_i) begin
        res_o.emit   = 1'b1;
        res_o.status = utf8d_pkg::StTrunc;
      end else begin
        rem_d  = need;
        part_d = lead_bits;
      end
    end else if (byte_i[7:6] != 2'b10) begin
      res_o.emit   = 1'b1;
      res_o.status = utf8d_pkg::StBadCont;
      rem_d        = '0;
      part_d       = '0;
      disc_d       = !last_i;
    end else if (rem_dec == '0) begin
      res_o.emit       = 1'b1;
      res_o.code_point = part_new;
      rem_d            = '0;
      part_d           = '0;
    end else if (last_i) begin
      res_o.emit   = 1'b1;
      res_o.status = utf8d_pkg::StTrunc;
      rem_d        = '0;
      part_d       = '0;
    end else begin
      rem_d  = rem_dec;
      part_d = part_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      part_q <= '0;
      disc_q <= 1'b0;
    end else if (advance_i) begin
      rem_q  <= rem_d;
      part_q <= part_d;
      disc_q <= disc_d;
    end
  end

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && last_i |=> rem_q == '0 && part_q == '0 && !disc_q)
    else $error("state not cleared after last byte");

  a_idle_part_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q == '0 |-> part_q == '0)
    else $error("partial value left outside a sequence");

  a_disc_no_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> rem_q == '0)
    else $error("sequence open while dropping bytes");

endmodule

/* tb/sv/tb_utf8_stream_decoder.sv */
`timescale 1ns / 100ps

module tb_utf8_stream_decoder;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned HoldLen    = 300;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned MaxPrints  = 100;
  localparam int unsigned DirRows    = 26;

  typedef struct packed {
    logic [utf8d_pkg::CpW-1:0] cp;
    utf8d_pkg::status_e        st;
    logic                      eos;
  } cp_word_t;

  typedef struct packed {
    logic [utf8d_pkg::ByteW-1:0] b;
    logic                        last;
    logic                        typed;
    logic                        has_word;
    cp_word_t                    word;
  } dir_row_t;

  localparam dir_row_t DirTable [DirRows] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, '{31'h0000_0000, utf8d_pkg::StOk, 1'b0}},
    '{8'h7F, 1'b1, 1'b1, 1'b1, '{31'h0000_007F, utf8d_pkg::StOk, 1'b1}},
    '{8'hFD, 1'b0, 1'b1, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'hBF, 1'b0, 1'b1, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'hBF, 1'b0, 1'b1, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'hBF, 1'b0, 1'b1, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'hBF, 1'b0, 1'b1, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'hBF, 1'b1, 1'b1, 1'b1, '{31'h7FFF_FFFF, utf8d_pkg::StOk, 1'b1}},
    '{8'hF8, 1'b0, 1'b0, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'h88, 1'b0, 1'b0, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'h80, 1'b0, 1'b0, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'h80, 1'b0, 1'b0, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'h80, 1'b1, 1'b0, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'hF0, 1'b0, 1'b0, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'h9F, 1'b0, 1'b0, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'h98, 1'b0, 1'b0, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'h80, 1'b1, 1'b0, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'h80, 1'b1, 1'b1, 1'b1, '{31'h0, utf8d_pkg::StBadLead, 1'b1}},
    '{8'hFF, 1'b0, 1'b1, 1'b1, '{31'h0, utf8d_pkg::StBadLead, 1'b0}},
    '{8'h42, 1'b1, 1'b1, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'hFE, 1'b1, 1'b1, 1'b1, '{31'h0, utf8d_pkg::StBadLead, 1'b1}},
    '{8'hE2, 1'b0, 1'b1, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'h41, 1'b1, 1'b1, 1'b1, '{31'h0, utf8d_pkg::StBadCont, 1'b1}},
    '{8'hE2, 1'b0, 1'b1, 1'b0, '{31'h0, utf8d_pkg::StOk, 1'b0}},
    '{8'h82, 1'b1, 1'b1, 1'b1, '{31'h0, utf8d_pkg::StTrunc, 1'b1}},
    '{8'hF8, 1'b1, 1'b1, 1'b1, '{31'h0, utf8d_pkg::StTrunc, 1'b1}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  utf8d_in_if  byte_if ();
  utf8d_out_if cp_if ();

  utf8_stream_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (cp_if)
  );

  always #5 clk_i = ~clk_i;

  // decoder state mirror
  logic [utf8d_pkg::RemW-1:0] seq_left;
  logic [utf8d_pkg::CpW-1:0]  seq_value;
  logic                       skipping;

  cp_word_t pending_words [$];
  cp_word_t seen_word;
  cp_word_t want_word;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_asks;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned bytes_decoded;
  int unsigned strings_sent;
  int unsigned words_checked;
  int unsigned status_count [4];

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= MaxPrints) begin
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    end
  endtask

  function automatic bit decode_byte(input logic [utf8d_pkg::ByteW-1:0] b, input logic last,
                                     output cp_word_t w);
    logic [utf8d_pkg::RemW-1:0] need;
    logic [utf8d_pkg::CpW-1:0]  bits;
    w = '{cp: '0, st: utf8d_pkg::StOk, eos: last};
    if (skipping) begin
      if (last) begin
        skipping = 1'b0;
      end
      return 1'b0;
    end
    bytes_decoded++;
    if (seq_left == '0) begin
      case (b) inside
        8'b0???????: begin
          w.cp = {23'b0, b};
          return 1'b1;
        end
        8'b110?????: begin
          need = 3'd1;
          bits = {20'b0, b[4:0], 6'b0};
        end
        8'b1110????: begin
          need = 3'd2;
          bits = {15'b0, b[3:0], 12'b0};
        end
        8'b11110???: begin
          need = 3'd3;
          bits = {10'b0, b[2:0], 18'b0};
        end
        8'b111110??: begin
          need = 3'd4;
          bits = {5'b0, b[1:0], 24'b0};
        end
        8'b1111110?: begin
          need = 3'd5;
          bits = {b[0], 30'b0};
        end
        default: begin
          skipping = !last;
          w.st = utf8d_pkg::StBadLead;
          return 1'b1;
        end
      endcase
      if (last) begin
        w.st = utf8d_pkg::StTrunc;
        return 1'b1;
      end
      seq_left  = need;
      seq_value = bits;
      return 1'b0;
    end
    if (b[7:6] != 2'b10) begin
      seq_left  = '0;
      seq_value = '0;
      skipping  = !last;
      w.st      = utf8d_pkg::StBadCont;
      return 1'b1;
    end
    seq_left  = seq_left - 3'd1;
    seq_value = seq_value | (utf8d_pkg::CpW'(b[5:0]) << (6 * seq_left));
    if (seq_left == '0) begin
      w.cp      = seq_value;
      seq_value = '0;
      return 1'b1;
    end
    if (last) begin
      seq_left  = '0;
      seq_value = '0;
      w.st      = utf8d_pkg::StTrunc;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // called at a falling edge, returns at the accepting rising edge
  task automatic put_byte(input logic [utf8d_pkg::ByteW-1:0] b, input logic last);
    byte_if.valid     <= 1'b1;
    byte_if.in_byte   <= b;
    byte_if.last_byte <= last;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    if (last) begin
      strings_sent++;
    end
  endtask

  task automatic sender_gap();
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  task automatic send_checked(input logic [utf8d_pkg::ByteW-1:0] b, input logic last);
    cp_word_t w;
    put_byte(b, last);
    if (decode_byte(b, last, w)) begin
      pending_words.insert(pending_words.size(), w);
    end
    sender_gap();
  endtask

  // hold the input idle until every expected word is out
  task automatic drain();
    byte_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_string();
    logic [utf8d_pkg::ByteW-1:0] str [$];
    logic [31:0]                 v;
    int                          nchars;
    int                          len;
    int                          kind;
    int                          idx;
    int                          r;
    nchars = $urandom_range(1, 8);
    for (int c = 0; c < nchars; c++) begin
      len = $urandom_range(1, 6);
      v   = $urandom;
      case (len)
        1:       str.insert(str.size(), {1'b0, v[6:0]});
        2:       str.insert(str.size(), {3'b110, v[4:0]});
        3:       str.insert(str.size(), {4'b1110, v[3:0]});
        4:       str.insert(str.size(), {5'b11110, v[2:0]});
        5:       str.insert(str.size(), {6'b111110, v[1:0]});
        default: str.insert(str.size(), {7'b1111110, v[0]});
      endcase
      for (int k = 1; k < len; k++) begin
        str.insert(str.size(), {2'b10, 6'($urandom)});
      end
    end
    kind = $urandom_range(99);
    if (kind < 6) begin
      r   = $urandom_range(65);
      idx = $urandom_range(str.size());
      str.insert(idx, (r < 64) ? (8'h80 | 8'(r)) : ((r == 64) ? 8'hFE : 8'hFF));
    end else if (kind < 12) begin
      if (str.size() > 1) begin
        idx      = $urandom_range(1, str.size() - 1);
        str[idx] = 8'($urandom);
      end
    end else if (kind < 18) begin
      if (str.size() > 1) begin
        r = $urandom_range(1, str.size() - 1);
        repeat (r) void'(str.pop_back());
      end
    end else if (kind < 22) begin
      str.delete();
      repeat ($urandom_range(1, 6)) str.insert(str.size(), 8'($urandom));
    end
    foreach (str[i]) begin
      send_checked(str[i], i == str.size() - 1);
    end
  endtask

  // receiver: random stalls plus a long hold-off whenever hold_asks is bumped
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    cp_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        cp_if.ready <= 1'b0;
      end else begin
        cp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cp_if.valid && cp_if.ready) begin
      seen_word = '{cp: cp_if.code_point, st: utf8d_pkg::status_e'(cp_if.status),
                    eos: cp_if.end_of_string};
      words_checked++;
      status_count[seen_word.st]++;
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", {1'b0, seen_word.cp}, 32'h0);
      end else begin
        want_word = pending_words.pop_front();
        if (seen_word.cp != want_word.cp) begin
          report_mismatch("code_point", {1'b0, seen_word.cp}, {1'b0, want_word.cp});
        end
        if (seen_word.st != want_word.st) begin
          report_mismatch("status", 32'(seen_word.st), 32'(want_word.st));
        end
        if (seen_word.eos != want_word.eos) begin
          report_mismatch("end_of_string", 32'(seen_word.eos), 32'(want_word.eos));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    cp_word_t w;
    bit       has;
    seq_left      = '0;
    seq_value     = '0;
    skipping      = 1'b0;
    hold_asks     = 0;
    cycle_count   = 0;
    fail_count    = 0;
    bytes_decoded = 0;
    strings_sent  = 0;
    words_checked = 0;
    status_count  = '{default: 0};
    send_idle_pct = 6;
    recv_idle_pct = 75;
    rst_ni            <= 1'b0;
    byte_if.valid     <= 1'b0;
    byte_if.in_byte   <= '0;
    byte_if.last_byte <= 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DirTable[i]) begin
      put_byte(DirTable[i].b, DirTable[i].last);
      has = decode_byte(DirTable[i].b, DirTable[i].last, w);
      if (DirTable[i].typed) begin
        if (DirTable[i].has_word) begin
          pending_words.insert(pending_words.size(), DirTable[i].word);
        end
      end else if (has) begin
        pending_words.insert(pending_words.size(), w);
      end
      sender_gap();
    end

    while (bytes_decoded < 470) send_random_string();
    drain();

    send_idle_pct = 75;
    recv_idle_pct = 6;
    while (bytes_decoded < 940) send_random_string();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks++;
    for (int i = 0; i < 48; i++) begin
      send_checked(8'($urandom_range(0, 127)), i == 47);
    end
    drain();
    while (bytes_decoded < 1400) send_random_string();
    drain();

    repeat (TailCycles) @(posedge clk_i);
    $display("decoded %0d bytes in %0d strings under sender, receiver and no stalls",
             bytes_decoded, strings_sent);
    $display("checked %0d words: %0d ok, %0d bad lead, %0d bad continuation, %0d truncated",
             words_checked, status_count[utf8d_pkg::StOk], status_count[utf8d_pkg::StBadLead],
             status_count[utf8d_pkg::StBadCont], status_count[utf8d_pkg::StTrunc]);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
